### rtl/core/bts_pkg.sv
`default_nettype none

package bts_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    // Fixed field widths
    localparam int COORD_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 4 * CHAN_W;
    localparam int OUT_W     = 16;
    localparam int DIM_W     = 9;
    localparam int NUM_BANKS = 4;

    // Wide enough for any cell index or image size over the parameter range
    localparam int IDX_CMP_W    = 17;
    // Wide enough for any bank address computation over the parameter range
    localparam int BADDR_CALC_W = 24;

    // Configuration port
    localparam int             CFG_ADDR_W       = 3;
    localparam int             CFG_DATA_W       = 32;
    localparam logic [0:0]     REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0]     REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET      = 9'd256;

    // Command codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic [CHAN_W-1:0]  texel_red;
        logic [CHAN_W-1:0]  texel_green;
        logic [CHAN_W-1:0]  texel_blue;
        logic [CHAN_W-1:0]  texel_alpha;
        logic [COORD_W-1:0] sample_x;
        logic [COORD_W-1:0] sample_y;
    } bts_cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_red;
        logic [OUT_W-1:0] out_green;
        logic [OUT_W-1:0] out_blue;
        logic [OUT_W-1:0] out_alpha;
    } bts_result_t;

    // Parity of the four neighbours, picks the bank each one comes from
    typedef struct packed {
        logic x0;
        logic x1;
        logic y0;
        logic y1;
    } bts_par_t;

endpackage

`default_nettype wire

### rtl/core/bilinear_texel_sampler_unit.sv
`default_nettype none

// Channel    Handshake                        Payload   Beat taken when
// ---------  -------------------------------  --------  -----------------------------------
// command    start / busy                     cmd       start high, busy low
// result     result_valid (one-cycle strobe)  result    the edge ending the strobe cycle
// config     psel penable pwrite / pready     pwdata    psel, penable, pwrite, pready high
//
// One command beat per cycle, sustained; busy stays low.
// A sample beat's result strobe shows once the beat has passed the input register,
// neighbour/bank address stage, banked store read, horizontal blend multiply and
// vertical blend multiply. A write beat lands in the store in the same stage where
// samples read, so order holds.
// Reset clears valid bits and sets both image dimensions to 256; the texel
// store is not cleared, and a texel must be written before it is sampled.
// Nothing stalls: the result side cannot hold off, so results never back up.
module bilinear_texel_sampler_unit #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bts_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            start,
    output logic                            busy,
    input  bts_pkg::bts_cmd_t               cmd,

    output logic                            result_valid,
    output bts_pkg::bts_result_t            result,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bts_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bts_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bts_pkg::*;

    // Store geometry: four banks split by column and row parity
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int BCOLS  = (MAX_WIDTH + 1) / 2;
    localparam int BROWS  = (MAX_HEIGHT + 1) / 2;
    localparam int BDEPTH = BCOLS * BROWS;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

    localparam logic [COORD_W-1:0] HALF_FIX = COORD_W'(1) << (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             cfg_wr;
    logic [0:0]       cfg_idx;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Last usable index: a size of 0 acts as 1, above the maximum acts as the maximum
    function automatic logic [IDX_CMP_W-1:0] last_index(input logic [DIM_W-1:0] d,
                                                         input logic [IDX_CMP_W-1:0] dmax);
        logic [IDX_CMP_W-1:0] de;
        de = IDX_CMP_W'(d);
        if (de == '0)
            last_index = '0;
        else if (de > dmax)
            last_index = dmax - 1'b1;
        else
            last_index = de - 1'b1;
    endfunction

    // Cell index after the half-texel shift; left of the first center snaps to 0
    function automatic logic [IDX_CMP_W-1:0] axis_cell(input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] s;
        s = c - HALF_FIX;
        if (c < HALF_FIX)
            axis_cell = '0;
        else
            axis_cell = IDX_CMP_W'(s >> FRAC_BITS);
    endfunction

    // Fraction after the half-texel shift; forced to 0 left of the first center
    function automatic logic [FRAC_BITS-1:0] axis_frac(input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] s;
        s = c - HALF_FIX;
        if (c < HALF_FIX)
            axis_frac = '0;
        else
            axis_frac = s[FRAC_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stage 0: command register
    // ------------------------------------------------------------------
    logic     accept;
    logic     p0_valid_reg;
    bts_cmd_t p0_cmd_reg;

    // The pipeline never stalls, so a beat is taken every cycle that start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else
        begin
            p0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_cmd_reg <= cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: neighbours, edge clamps and bank addresses
    // ------------------------------------------------------------------
    logic [IDX_CMP_W-1:0] last_x;
    logic [IDX_CMP_W-1:0] last_y;
    logic [IDX_CMP_W-1:0] cell_x;
    logic [IDX_CMP_W-1:0] cell_y;
    logic [IDX_CMP_W-1:0] x0_c;
    logic [IDX_CMP_W-1:0] x1_c;
    logic [IDX_CMP_W-1:0] y0_c;
    logic [IDX_CMP_W-1:0] y1_c;
    logic [XW-1:0]        x0;
    logic [XW-1:0]        x1;
    logic [YW-1:0]        y0;
    logic [YW-1:0]        y1;
    logic [XW-1:0]        col;
    logic [YW-1:0]        row;

    logic                 p1_wr_en_next;
    logic                 p1_rd_en_next;
    logic [1:0]           p1_wr_bank_next;
    logic [BAW-1:0]       p1_wr_addr_next;
    logic [TEXEL_W-1:0]   p1_wr_data_next;
    logic [BAW-1:0]       p1_rd_addr_next [NUM_BANKS];
    bts_par_t             p1_par_next;

    logic                 p1_wr_en_reg;
    logic                 p1_rd_en_reg;
    logic [1:0]           p1_wr_bank_reg;
    logic [BAW-1:0]       p1_wr_addr_reg;
    logic [TEXEL_W-1:0]   p1_wr_data_reg;
    logic [BAW-1:0]       p1_rd_addr_reg [NUM_BANKS];
    bts_par_t             p1_par_reg;
    logic [FRAC_BITS-1:0] p1_u_reg;
    logic [FRAC_BITS-1:0] p1_v_reg;

    always_comb
    begin
        last_x = last_index(width_reg, IDX_CMP_W'(MAX_WIDTH));
        last_y = last_index(height_reg, IDX_CMP_W'(MAX_HEIGHT));
        cell_x = axis_cell(p0_cmd_reg.sample_x);
        cell_y = axis_cell(p0_cmd_reg.sample_y);

        // Clamp the low neighbour to the last column/row; the high one follows it
        x0_c = (cell_x > last_x) ? last_x : cell_x;
        y0_c = (cell_y > last_y) ? last_y : cell_y;
        x1_c = (x0_c == last_x) ? last_x : x0_c + 1'b1;
        y1_c = (y0_c == last_y) ? last_y : y0_c + 1'b1;
        x0   = XW'(x0_c);
        x1   = XW'(x1_c);
        y0   = YW'(y0_c);
        y1   = YW'(y1_c);

        p1_par_next.x0 = x0[0];
        p1_par_next.x1 = x1[0];
        p1_par_next.y0 = y0[0];
        p1_par_next.y1 = y1[0];

        // Each bank serves the neighbour whose parity matches; when both
        // neighbours clamp to one texel the other bank's read is unused
        col = '0;
        row = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            col = (x0[0] == 1'(b)) ? x0 : x1;
            row = (y0[0] == 1'(b >> 1)) ? y0 : y1;
            p1_rd_addr_next[b] = BAW'(BADDR_CALC_W'(row >> 1) * BADDR_CALC_W'(BCOLS)
                                      + BADDR_CALC_W'(col >> 1));
        end

        p1_rd_en_next = p0_valid_reg && (p0_cmd_reg.func == FUNC_SAMPLE);

        // Drop writes that fall outside the store
        p1_wr_en_next = p0_valid_reg && (p0_cmd_reg.func == FUNC_WRITE)
                        && (IDX_CMP_W'(p0_cmd_reg.texel_x) < IDX_CMP_W'(MAX_WIDTH))
                        && (IDX_CMP_W'(p0_cmd_reg.texel_y) < IDX_CMP_W'(MAX_HEIGHT));
        p1_wr_bank_next = {p0_cmd_reg.texel_y[0], p0_cmd_reg.texel_x[0]};
        p1_wr_addr_next = BAW'(BADDR_CALC_W'(p0_cmd_reg.texel_y >> 1) * BADDR_CALC_W'(BCOLS)
                               + BADDR_CALC_W'(p0_cmd_reg.texel_x >> 1));
        p1_wr_data_next = {p0_cmd_reg.texel_alpha, p0_cmd_reg.texel_blue,
                           p0_cmd_reg.texel_green, p0_cmd_reg.texel_red};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_wr_en_reg <= 1'b0;
            p1_rd_en_reg <= 1'b0;
        end
        else
        begin
            p1_wr_en_reg <= p1_wr_en_next;
            p1_rd_en_reg <= p1_rd_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_wr_bank_reg <= p1_wr_bank_next;
        p1_wr_addr_reg <= p1_wr_addr_next;
        p1_wr_data_reg <= p1_wr_data_next;
        p1_rd_addr_reg <= p1_rd_addr_next;
        p1_par_reg     <= p1_par_next;
        p1_u_reg       <= axis_frac(p0_cmd_reg.sample_x);
        p1_v_reg       <= axis_frac(p0_cmd_reg.sample_y);
    end

    // ------------------------------------------------------------------
    // Stage 2: banked texel store, read data registered inside
    // ------------------------------------------------------------------
    logic [TEXEL_W-1:0]   bank_data [NUM_BANKS];
    logic                 p2_valid_reg;
    bts_par_t             p2_par_reg;
    logic [FRAC_BITS-1:0] p2_u_reg;
    logic [FRAC_BITS-1:0] p2_v_reg;
    logic [TEXEL_W-1:0]   quad [NUM_BANKS];

    bts_store #(
        .BDEPTH (BDEPTH),
        .BAW    (BAW)
    ) u_store (
        .clk     (clk),
        .wr_en   (p1_wr_en_reg),
        .wr_bank (p1_wr_bank_reg),
        .wr_addr (p1_wr_addr_reg),
        .wr_data (p1_wr_data_reg),
        .rd_en   (p1_rd_en_reg),
        .rd_addr (p1_rd_addr_reg),
        .rd_data (bank_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_rd_en_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_par_reg <= p1_par_reg;
        p2_u_reg   <= p1_u_reg;
        p2_v_reg   <= p1_v_reg;
    end

    // Route bank outputs to the four neighbours: top-left, top-right,
    // bottom-left, bottom-right
    always_comb
    begin
        quad[0] = bank_data[{p2_par_reg.y0, p2_par_reg.x0}];
        quad[1] = bank_data[{p2_par_reg.y0, p2_par_reg.x1}];
        quad[2] = bank_data[{p2_par_reg.y1, p2_par_reg.x0}];
        quad[3] = bank_data[{p2_par_reg.y1, p2_par_reg.x1}];
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: horizontal then vertical blend
    // ------------------------------------------------------------------
    bts_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (p2_valid_reg),
        .texel      (quad),
        .frac_u     (p2_u_reg),
        .frac_v     (p2_v_reg),
        .out_valid  (result_valid),
        .out_result (result)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every sample beat has its result strobe taken at the end of the pipeline; a write beat does not
    a_sample_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 (result_valid == $past(cmd.func == FUNC_SAMPLE, 5)))
        else $error("sample beat and result strobe out of step");

    // No result strobe without a matching earlier sample beat
    a_no_invented_result : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept && (cmd.func == FUNC_SAMPLE), 5))
        else $error("result strobe without a sample beat");

    // One beat per stage: the store never sees a write and a read together
    a_store_port_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        !(p1_wr_en_reg && p1_rd_en_reg))
        else $error("store write and read in the same cycle");

endmodule

`default_nettype wire

### rtl/core/bts_store.sv
`default_nettype none

module bts_store #(
    parameter int BDEPTH = 32768,
    parameter int BAW    = 15
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_bank,
    input  logic [BAW-1:0]               wr_addr,
    input  logic [bts_pkg::TEXEL_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [BAW-1:0]               rd_addr [bts_pkg::NUM_BANKS],
    output logic [bts_pkg::TEXEL_W-1:0]  rd_data [bts_pkg::NUM_BANKS]
);
    import bts_pkg::*;

    // One bank per (row parity, column parity); a 2x2 footprint hits each bank once
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [TEXEL_W-1:0] bank_mem [BDEPTH];
        logic [TEXEL_W-1:0] rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                bank_mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data_reg <= bank_mem[rd_addr[b]];
            end
        end

        assign rd_data[b] = rd_data_reg;
    end

endmodule

`default_nettype wire

### rtl/core/bts_blend.sv
`default_nettype none

module bts_blend #(
    parameter int FRAC_BITS = bts_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [bts_pkg::TEXEL_W-1:0]  texel [bts_pkg::NUM_BANKS],
    input  logic [FRAC_BITS-1:0]         frac_u,
    input  logic [FRAC_BITS-1:0]         frac_v,
    output logic                         out_valid,
    output bts_pkg::bts_result_t         out_result
);
    import bts_pkg::*;

    localparam int WW = FRAC_BITS + 1;            // weight width
    localparam int TW = CHAN_W + FRAC_BITS;       // row blend width
    localparam int PW = TW + 1;                   // row blend product width
    localparam int SW = CHAN_W + 2 * FRAC_BITS;   // final sum width
    localparam int QW = SW + 1;                   // final product width
    localparam logic [WW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 a_valid_reg;
    logic [TW-1:0]        a_top_reg [4];
    logic [TW-1:0]        a_bot_reg [4];
    logic [FRAC_BITS-1:0] a_v_reg;
    logic [TW-1:0]        a_top_next [4];
    logic [TW-1:0]        a_bot_next [4];

    logic                 b_valid_reg;
    bts_result_t          b_result_reg;
    logic [OUT_W-1:0]     b_out_next [4];

    logic [WW-1:0]        wu0;
    logic [WW-1:0]        wu1;
    logic [WW-1:0]        wv0;
    logic [WW-1:0]        wv1;
    logic [SW-1:0]        sum [4];

    // Horizontal blend of the top and bottom rows
    always_comb
    begin
        wu1 = WW'(frac_u);
        wu0 = ONE_FIX - wu1;
        for (int ch = 0; ch < 4; ch++)
        begin
            a_top_next[ch] = TW'(PW'(texel[0][ch*CHAN_W +: CHAN_W]) * PW'(wu0)
                               + PW'(texel[1][ch*CHAN_W +: CHAN_W]) * PW'(wu1));
            a_bot_next[ch] = TW'(PW'(texel[2][ch*CHAN_W +: CHAN_W]) * PW'(wu0)
                               + PW'(texel[3][ch*CHAN_W +: CHAN_W]) * PW'(wu1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_top_reg <= a_top_next;
        a_bot_reg <= a_bot_next;
        a_v_reg   <= frac_v;
    end

    // Vertical blend; keep the top 16 bits, which is the value times 256
    always_comb
    begin
        wv1 = WW'(a_v_reg);
        wv0 = ONE_FIX - wv1;
        for (int ch = 0; ch < 4; ch++)
        begin
            sum[ch] = SW'(QW'(a_top_reg[ch]) * QW'(wv0) + QW'(a_bot_reg[ch]) * QW'(wv1));
            b_out_next[ch] = sum[ch][SW-1 -: OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_result_reg.out_red   <= b_out_next[0];
        b_result_reg.out_green <= b_out_next[1];
        b_result_reg.out_blue  <= b_out_next[2];
        b_result_reg.out_alpha <= b_out_next[3];
    end

    assign out_valid  = b_valid_reg;
    assign out_result = b_result_reg;

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

// Self-checking bench for the bilinear texel sampler.
//
// Command beats go in through start/busy. Write beats load one texel.
// Sample beats must come back as one result strobe each. A scoreboard class
// mirrors the texel store and the two image-size registers. It predicts every
// blend at the moment its sample beat is accepted, and checks the strobed
// results in order.
//
// Flow:
//   - directed beats at the reset size: edge, half-texel and fraction extremes
//   - six register settings, extremes among them (zero, one, two, 511, random)
//   - random beats within each setting; every sample first loads any of its
//     four neighbours that were never written, so nothing undefined is read
//   - sender gaps at 18 %, then 52 %, then none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    // Timing of the bench
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int LATENCY      = 5;              // accept edge to the edge taking the result
    localparam int DRAIN_CYCLES = LATENCY + 3;    // lets a trailing write land
    localparam int IDLE_LIMIT   = 2000;           // watchdog, cycles with no beat
    localparam int NUM_SETTINGS = 6;
    localparam int PHASE_ITEMS  = 270;

    // Blend arithmetic at the block's default parameters
    localparam int FB          = DEF_FRAC_BITS;
    localparam int ONE_FIX     = 1 << FB;
    localparam int HALF_FIX    = 1 << (FB - 1);
    localparam int BLEND_SHIFT = 2 * FB - 8;
    localparam int ROW_PITCH   = DEF_MAX_WIDTH;
    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    // Mirror of the texel store, the image size and the pending blends
    class sample_scoreboard;
        logic [TEXEL_W-1:0] texels [STORE_DEPTH];
        bit                 loaded [STORE_DEPTH];
        int                 dim_w = DEF_MAX_WIDTH;
        int                 dim_h = DEF_MAX_HEIGHT;
        bts_result_t        expected_blends [$];
        int                 n_samples;
        int                 n_checked;
        int                 n_errors;

        // A size of zero acts as one; anything past the store acts as its edge
        function int effective(logic [DIM_W-1:0] v, int maxv);
            if (v == '0) return 1;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        function void set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
            dim_w = effective(w, DEF_MAX_WIDTH);
            dim_h = effective(h, DEF_MAX_HEIGHT);
        endfunction

        // Shift by half a texel, then clamp both neighbours to the last texel.
        // Left of the first center, pin to texel 0 with no fraction.
        function void locate(input logic [COORD_W-1:0] c, input int size,
                             output int lo, output int hi, output int frac);
            int s;
            if (int'(c) < HALF_FIX) begin
                lo   = 0;
                frac = 0;
            end
            else begin
                s    = int'(c) - HALF_FIX;
                lo   = s >> FB;
                frac = s & (ONE_FIX - 1);
            end
            if (lo > size - 1) lo = size - 1;
            hi = (lo + 1 > size - 1) ? size - 1 : lo + 1;
        endfunction

        function bit is_loaded(int x, int y);
            return loaded[y * ROW_PITCH + x];
        endfunction

        function void report(string msg);
            n_errors++;
            if (n_errors <= 10) $display("tb_top: mismatch: %s", msg);
        endfunction

        function void take_command(bts_cmd_t c);
            int                 x0, x1, y0, y1, u, v;
            int                 a, b, cc, d, top, bot, sum;
            logic [TEXEL_W-1:0] t00, t10, t01, t11;
            logic [OUT_W-1:0]   chan [4];
            bts_result_t        e;
            if (c.func == FUNC_WRITE) begin
                texels[int'(c.texel_y) * ROW_PITCH + int'(c.texel_x)] =
                    {c.texel_alpha, c.texel_blue, c.texel_green, c.texel_red};
                loaded[int'(c.texel_y) * ROW_PITCH + int'(c.texel_x)] = 1'b1;
                return;
            end
            locate(c.sample_x, dim_w, x0, x1, u);
            locate(c.sample_y, dim_h, y0, y1, v);
            t00 = texels[y0 * ROW_PITCH + x0];
            t10 = texels[y0 * ROW_PITCH + x1];
            t01 = texels[y1 * ROW_PITCH + x0];
            t11 = texels[y1 * ROW_PITCH + x1];
            for (int ch = 0; ch < 4; ch++) begin
                a   = int'(t00[ch*CHAN_W +: CHAN_W]);
                b   = int'(t10[ch*CHAN_W +: CHAN_W]);
                cc  = int'(t01[ch*CHAN_W +: CHAN_W]);
                d   = int'(t11[ch*CHAN_W +: CHAN_W]);
                top = a  * (ONE_FIX - u) + b * u;
                bot = cc * (ONE_FIX - u) + d * u;
                sum = top * (ONE_FIX - v) + bot * v;
                chan[ch] = OUT_W'(sum >> BLEND_SHIFT);
            end
            e.out_red   = chan[0];
            e.out_green = chan[1];
            e.out_blue  = chan[2];
            e.out_alpha = chan[3];
            expected_blends.push_back(e);
            n_samples++;
        endfunction

        function void check_sample(bts_result_t r);
            bts_result_t e;
            if (expected_blends.size() == 0) begin
                report($sformatf("result %h with no sample pending", r));
                return;
            end
            e = expected_blends.pop_front();
            n_checked++;
            if (r.out_red !== e.out_red || r.out_green !== e.out_green ||
                r.out_blue !== e.out_blue || r.out_alpha !== e.out_alpha)
                report($sformatf("blend %0d: expected rgba %h %h %h %h, got %h %h %h %h",
                                 n_checked, e.out_red, e.out_green, e.out_blue,
                                 e.out_alpha, r.out_red, r.out_green, r.out_blue,
                                 r.out_alpha));
        endfunction

        function int pending();
            return expected_blends.size();
        endfunction
    endclass

    // DUT signals; every input is known from time zero
    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    bts_cmd_t              cmd     = '0;
    logic                  result_valid;
    bts_result_t           result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sample_scoreboard sb;
    int               idle_pct   = 18;
    int               n_beats    = 0;
    int               n_settings = 0;
    int               idle_count = 0;

    bilinear_texel_sampler_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Check every result strobe against the oldest pending blend
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1) sb.check_sample(result);
    end

    // Watchdog: count edges that move no beat on any port, give up at the limit
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 ||
            (psel && penable && pready === 1'b1))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("tb_top: watchdog, no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Fill every bit at random; callers then overwrite what matters
    function automatic bts_cmd_t random_cmd();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bts_cmd_t'(bits[$bits(bts_cmd_t)-1:0]);
    endfunction

    // Hold one command until the edge that takes it; idle first at the current rate.
    // Returns just after the accepting edge, with the beat already noted.
    task automatic push_cmd(input bts_cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy !== 1'b0);
        sb.take_command(c);
        n_beats++;
    endtask

    task automatic write_texel(input logic [7:0] x, input logic [7:0] y,
                               input logic [TEXEL_W-1:0] rgba);
        bts_cmd_t c;
        c = random_cmd();
        c.func    = FUNC_WRITE;
        c.texel_x = x;
        c.texel_y = y;
        {c.texel_alpha, c.texel_blue, c.texel_green, c.texel_red} = rgba;
        push_cmd(c);
    endtask

    // Load any neighbour never written, then send the sample itself
    task automatic sample_at(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        bts_cmd_t c;
        int       xs [2];
        int       ys [2];
        int       u;
        int       v;
        sb.locate(sx, sb.dim_w, xs[0], xs[1], u);
        sb.locate(sy, sb.dim_h, ys[0], ys[1], v);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                if (!sb.is_loaded(xs[i], ys[j]))
                    write_texel(8'(xs[i]), 8'(ys[j]), $urandom());
        c = random_cmd();
        c.func     = FUNC_SAMPLE;
        c.sample_x = sx;
        c.sample_y = sy;
        push_cmd(c);
    endtask

    // Coordinate mix: any 16-bit value, near the origin, or over the image and
    // one texel past it, so both edge clamps see plenty of traffic
    function automatic logic [COORD_W-1:0] pick_coord(int size);
        int sel;
        int span;
        int ip;
        sel = int'($urandom_range(9));
        if (sel < 4) return COORD_W'($urandom());
        span = (sel < 7 && size > 16) ? 16 : size;
        ip   = int'($urandom_range(span, 0));
        if (ip > 255) ip = 255;
        return COORD_W'((ip << 8) | int'($urandom_range(255)));
    endfunction

    // Drop start, wait out every pending blend, then let trailing writes land
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] a,
                             input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [CFG_ADDR_W-1:0] a,
                            output logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        d = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the image size with the block idle, read both registers back
    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        logic [CFG_DATA_W-1:0] rd;
        logic [CFG_ADDR_W-1:0] a;
        logic [DIM_W-1:0]      want;
        settle();
        apb_write({REG_IMAGE_WIDTH, 2'b00}, CFG_DATA_W'(w));
        apb_write({REG_IMAGE_HEIGHT, 2'b00}, CFG_DATA_W'(h));
        for (int i = 0; i < 2; i++) begin
            a    = (i == 0) ? {REG_IMAGE_WIDTH, 2'b00} : {REG_IMAGE_HEIGHT, 2'b00};
            want = (i == 0) ? w : h;
            apb_read(a, rd);
            if (rd[DIM_W-1:0] !== want)
                sb.report($sformatf("register at %0d reads %h, wrote %h", a, rd, want));
        end
        sb.set_dims(w, h);
        n_settings++;
    endtask

    initial
    begin
        logic [DIM_W-1:0] set_w [NUM_SETTINGS];
        logic [DIM_W-1:0] set_h [NUM_SETTINGS];
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               phase_end;

        set_w = '{9'd256, 9'd1, 9'd0, 9'd3, 9'd511, 9'd0};
        set_h = '{9'd256, 9'd1, 9'd511, 9'd2, 9'd17, 9'd0};
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset size. Load a checkerboard of all-ones and
        // all-zeros texels in the corner, so the blend weights show directly.
        write_texel(8'd0, 8'd0, 32'hFFFF_FFFF);
        write_texel(8'd1, 8'd0, 32'h0000_0000);
        write_texel(8'd0, 8'd1, 32'h0000_0000);
        write_texel(8'd1, 8'd1, 32'hFFFF_FFFF);
        write_texel(8'd255, 8'd255, 32'hFF00_FF00);
        write_texel(8'd254, 8'd255, 32'h00FF_00FF);
        sample_at(16'h0000, 16'h0000);    // origin, shifted coordinate below zero
        sample_at(16'h007F, 16'h007F);    // just short of the first texel center
        sample_at(16'h0080, 16'h0080);    // on the first center, no fraction
        sample_at(16'h0100, 16'h0100);    // midway between four texels
        sample_at(16'h017F, 16'h0080);    // largest fraction across
        sample_at(16'h0080, 16'h017F);    // largest fraction down
        sample_at(16'hFFFF, 16'hFFFF);    // far corner, both neighbours clamp
        sample_at(16'hFF80, 16'h0000);    // last column center, top edge
        sample_at(16'h0000, 16'hFFFF);    // left edge, bottom edge
        sample_at(16'h8080, 16'h4040);    // mid image

        // Random beats under each register setting; the last setting is random
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            w = set_w[p];
            h = set_h[p];
            if (p == NUM_SETTINGS - 1) begin
                w = DIM_W'($urandom());
                h = DIM_W'($urandom());
            end
            configure(w, h);
            idle_pct  = (p < 2) ? 18 : (p < 4) ? 52 : 0;
            phase_end = n_beats + PHASE_ITEMS;
            while (n_beats < phase_end) begin
                if ($urandom_range(99) < 20)
                    write_texel(8'($urandom()), 8'($urandom()), $urandom());
                else
                    sample_at(pick_coord(sb.dim_w), pick_coord(sb.dim_h));
            end
        end

        settle();
        $display("tb_top: %0d command beats, %0d of them samples, over %0d register settings",
                 n_beats, sb.n_samples, n_settings);
        $display("tb_top: %0d blends checked, %0d mismatches, %0d still pending",
                 sb.n_checked, sb.n_errors, sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
